// ===== rtl/kmer_sorted_bucket_hash_index_assert.svh =====
// Assertion macros shared by the checker.
`ifndef KMER_SORTED_BUCKET_HASH_INDEX_ASSERT_SVH
`define KMER_SORTED_BUCKET_HASH_INDEX_ASSERT_SVH
`define KSB_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KSB_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/ksbhi_pkg.sv =====
`default_nettype none
package ksbhi_pkg;
  localparam int unsigned BucketCountDef = 1024;
  localparam int unsigned BucketDepthDef = 16;
  localparam int unsigned LinearLimitDef = 8;
  localparam int unsigned MaxKeyWordsDef = 4;
  localparam int unsigned WordW = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] REG_KEY_WORDS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TAIL_SHIFT = 1'd1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic operation;
    logic [WordW-1:0] key_word0;
    logic [WordW-1:0] key_word1;
    logic [WordW-1:0] key_word2;
    logic [WordW-1:0] key_word3;
    logic [WordW-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [WordW-1:0] found_position;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_STORE, S_POS_RD, S_POS_WAIT, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/ksbhi_if.sv =====
`default_nettype none
interface ksbhi_in_if;
  logic valid;
  logic ready;
  ksbhi_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ksbhi_out_if;
  logic valid;
  logic ready;
  ksbhi_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ksbhi_store.sv =====
`default_nettype none
module ksbhi_store #(
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [DW-1:0] wdata,
  input wire logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/kmer_sorted_bucket_hash_index.sv =====
// Sorted-bucket hash index of k-mer keys to 64-bit positions.
// Input channel in_*: one word per operation (insert or lookup), key words
// and a position. Output channel out_*: one word per input, with the found
// position and a status code. Registers key_words and tail_shift are set
// through cfg_we, cfg_index and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce.
// The block works on one word at a time. After accepting a word it reads
// the bucket fill count, then for each compared entry reads the key memory
// and compares. An insert into a bucket that is not full moves the entries
// above its slot up one at a time, each by a read and a write, and then
// stores the new entry; a lookup hit reads the position. Finally the output
// register is loaded. The key memory has one read and one write port,
// which bounds the scan and the shift.
// After reset the fill memory is cleared in one pass over all BUCKET_COUNT
// buckets, during which in_ready stays low. Key words are compared
// combinationally over the active key words.
// The result is held in an output register until out_ready; the next
// input is taken once that register is empty.
`default_nettype none
module kmer_sorted_bucket_hash_index #(
  parameter int unsigned BUCKET_COUNT = ksbhi_pkg::BucketCountDef,
  parameter int unsigned BUCKET_DEPTH = ksbhi_pkg::BucketDepthDef,
  parameter int unsigned LINEAR_LIMIT = ksbhi_pkg::LinearLimitDef
) (
  input wire logic clk,
  input wire logic rst_n,
  ksbhi_in_if.sink in_ch,
  ksbhi_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [ksbhi_pkg::CfgIdxW-1:0] cfg_index,
  input wire logic [ksbhi_pkg::CfgDataW-1:0] cfg_data
);
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned SW = $clog2(BUCKET_DEPTH);
  localparam int unsigned NW = SW + 1;
  localparam int unsigned AW = BW + SW;
  localparam int unsigned KW = 4 * ksbhi_pkg::WordW;
  localparam int unsigned LIN = (LINEAR_LIMIT > BUCKET_DEPTH) ? BUCKET_DEPTH + 1 : LINEAR_LIMIT;

  ksbhi_pkg::state_t state_r, state_nxt;
  logic [2:0] kw_r;
  logic [5:0] sh_r;
  logic [KW-1:0] key_r;
  logic [ksbhi_pkg::WordW-1:0] pos_r;
  logic op_r;
  logic [BW-1:0] bkt_r;
  logic [NW-1:0] n_r, slot_r, lo_r, hi_r, idx_r, probe_r;
  logic clr_r;
  logic [BW-1:0] clr_cnt_r;
  logic ov_r;
  ksbhi_pkg::out_word_t ow_r;
  logic [NW-1:0] fill_mem [BUCKET_COUNT];
  logic [NW-1:0] fill_q;

  logic [2:0] kwe;
  logic [KW-1:0] key_in;
  logic [ksbhi_pkg::WordW-1:0] lastw, prevw, h;

  always_comb begin
    kwe = (kw_r == 3'd0) ? 3'd1 : ((kw_r > 3'd4) ? 3'd4 : kw_r);
    key_in = {in_ch.data.key_word0,
              (kwe > 3'd1) ? in_ch.data.key_word1 : 64'd0,
              (kwe > 3'd2) ? in_ch.data.key_word2 : 64'd0,
              (kwe > 3'd3) ? in_ch.data.key_word3 : 64'd0};
    case (kwe)
      3'd2: begin lastw = in_ch.data.key_word1; prevw = in_ch.data.key_word0; end
      3'd3: begin lastw = in_ch.data.key_word2; prevw = in_ch.data.key_word1; end
      3'd4: begin lastw = in_ch.data.key_word3; prevw = in_ch.data.key_word2; end
      default: begin lastw = in_ch.data.key_word0; prevw = '0; end
    endcase
    h = (sh_r != 6'd0) ? (lastw | (prevw << sh_r)) : lastw;
  end

  // key memory read/write and position memory
  logic kwe_en, pwe_en;
  logic [AW-1:0] kwa, kra, pwa, pra;
  logic [KW-1:0] kwd, krd;
  logic [ksbhi_pkg::WordW-1:0] pwd, prd;

  ksbhi_store #(.AW(AW), .DW(KW)) u_keys (.clk(clk), .we(kwe_en), .waddr(kwa),
    .wdata(kwd), .raddr(kra), .rdata(krd));
  ksbhi_store #(.AW(AW), .DW(ksbhi_pkg::WordW)) u_pos (.clk(clk), .we(pwe_en),
    .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

  logic [KW-1:0] kmask, a_m, b_m;
  logic lt, eq;
  always_comb begin
    kmask = {64'hFFFF_FFFF_FFFF_FFFF,
             (kwe > 3'd1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0,
             (kwe > 3'd2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0,
             (kwe > 3'd3) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0};
    a_m = key_r & kmask;
    b_m = krd & kmask;
    lt = a_m < b_m;
    eq = a_m == b_m;
  end

  wire in_fire = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ksbhi_pkg::S_IDLE) && !clr_r && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = ow_r;

  // Search plan: a linear lookup compares entries 0..n-1 in order; a linear insert
  // checks both ends, then entries from 1 up; binary mode checks both ends, then halves [lo, hi].
  logic bin;
  assign bin = n_r >= NW'(LIN);

  // Decision in S_SCAN_CMP against entry probe_r.
  logic done_s, hit_s;
  logic [NW-1:0] res_s, lo_n, hi_n, probe_n, mid;
  logic [1:0] phase_n;
  logic [1:0] phase_r;
  always_comb begin
    done_s = 1'b0; hit_s = 1'b0; res_s = '0;
    lo_n = lo_r; hi_n = hi_r; probe_n = probe_r; phase_n = phase_r;
    mid = NW'((({1'b0, lo_r} + {1'b0, hi_r}) >> 1));
    if (op_r == ksbhi_pkg::OP_INSERT) begin
      if (phase_r == 2'd0) begin
        if (lt || eq) begin done_s = 1'b1; res_s = '0; end
        else begin phase_n = 2'd1; probe_n = n_r - 1'b1; end
      end else if (phase_r == 2'd1) begin
        if (!lt) begin done_s = 1'b1; res_s = n_r; end
        else if (!bin) begin phase_n = 2'd2; probe_n = NW'(1); end
        else if (hi_r - lo_r <= NW'(1)) begin done_s = 1'b1; res_s = hi_r; end
        else begin phase_n = 2'd3; probe_n = mid; end
      end else if (phase_r == 2'd2) begin
        if (lt || eq) begin done_s = 1'b1; res_s = probe_r; end
        else if (probe_r + 1'b1 >= n_r) begin done_s = 1'b1; res_s = n_r; end
        else probe_n = probe_r + 1'b1;
      end else begin
        if (eq) begin done_s = 1'b1; res_s = probe_r; end
        else begin
          if (lt) hi_n = probe_r; else lo_n = probe_r;
          if (hi_n - lo_n <= NW'(1)) begin done_s = 1'b1; res_s = hi_n; end
          else probe_n = NW'((({1'b0, lo_n} + {1'b0, hi_n}) >> 1));
        end
      end
    end else begin
      if (!bin) begin
        if (eq) begin done_s = 1'b1; hit_s = 1'b1; res_s = probe_r; end
        else if (probe_r + 1'b1 >= n_r) done_s = 1'b1;
        else probe_n = probe_r + 1'b1;
      end else if (phase_r == 2'd0) begin
        if (eq) begin done_s = 1'b1; hit_s = 1'b1; res_s = probe_r; end
        else begin phase_n = 2'd1; probe_n = n_r - 1'b1; end
      end else if (phase_r == 2'd1) begin
        if (eq) begin done_s = 1'b1; hit_s = 1'b1; res_s = probe_r; end
        else if (hi_r - lo_r <= NW'(1)) done_s = 1'b1;
        else begin phase_n = 2'd3; probe_n = mid; end
      end else begin
        if (eq) begin done_s = 1'b1; hit_s = 1'b1; res_s = probe_r; end
        else begin
          if (lt) hi_n = probe_r; else lo_n = probe_r;
          if (hi_n - lo_n <= NW'(1)) done_s = 1'b1;
          else probe_n = NW'((({1'b0, lo_n} + {1'b0, hi_n}) >> 1));
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ksbhi_pkg::S_IDLE: if (in_fire) state_nxt = ksbhi_pkg::S_FILL;
      ksbhi_pkg::S_FILL: begin
        if (op_r == ksbhi_pkg::OP_INSERT && fill_q >= NW'(BUCKET_DEPTH))
          state_nxt = ksbhi_pkg::S_DONE;
        else if (fill_q == '0)
          state_nxt = (op_r == ksbhi_pkg::OP_INSERT) ? ksbhi_pkg::S_STORE
                                                     : ksbhi_pkg::S_DONE;
        else state_nxt = ksbhi_pkg::S_SCAN_RD;
      end
      ksbhi_pkg::S_SCAN_RD: state_nxt = ksbhi_pkg::S_SCAN_CMP;
      ksbhi_pkg::S_SCAN_CMP: begin
        if (!done_s) state_nxt = ksbhi_pkg::S_SCAN_RD;
        else if (op_r == ksbhi_pkg::OP_INSERT)
          state_nxt = (res_s == n_r) ? ksbhi_pkg::S_STORE : ksbhi_pkg::S_SHIFT_RD;
        else state_nxt = hit_s ? ksbhi_pkg::S_POS_RD : ksbhi_pkg::S_DONE;
      end
      ksbhi_pkg::S_SHIFT_RD: state_nxt = ksbhi_pkg::S_SHIFT_WR;
      ksbhi_pkg::S_SHIFT_WR:
        state_nxt = (idx_r - 1'b1 == slot_r) ? ksbhi_pkg::S_STORE : ksbhi_pkg::S_SHIFT_RD;
      ksbhi_pkg::S_STORE: state_nxt = ksbhi_pkg::S_DONE;
      ksbhi_pkg::S_POS_RD: state_nxt = ksbhi_pkg::S_POS_WAIT;
      ksbhi_pkg::S_POS_WAIT: state_nxt = ksbhi_pkg::S_DONE;
      ksbhi_pkg::S_DONE: state_nxt = ksbhi_pkg::S_IDLE;
      default: state_nxt = ksbhi_pkg::S_IDLE;
    endcase
  end

  logic [1:0] status_r;
  logic [SW-1:0] probe_lo, idx_lo, idxm1_lo, slot_lo;
  assign probe_lo = probe_r[SW-1:0];
  assign idx_lo = idx_r[SW-1:0];
  assign idxm1_lo = SW'(idx_r - 1'b1);
  assign slot_lo = slot_r[SW-1:0];

  always_comb begin
    kra = {bkt_r, probe_lo};
    pra = {bkt_r, slot_lo};
    kwe_en = 1'b0; pwe_en = 1'b0;
    kwa = {bkt_r, idx_lo}; pwa = {bkt_r, idx_lo};
    kwd = krd; pwd = prd;
    case (state_r)
      ksbhi_pkg::S_SHIFT_RD: begin kra = {bkt_r, idxm1_lo}; pra = {bkt_r, idxm1_lo}; end
      ksbhi_pkg::S_SHIFT_WR: begin kwe_en = 1'b1; pwe_en = 1'b1; end
      ksbhi_pkg::S_STORE: begin
        kwe_en = 1'b1; pwe_en = 1'b1;
        kwa = {bkt_r, slot_lo}; pwa = {bkt_r, slot_lo};
        kwd = key_r; pwd = pos_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fill_q <= fill_mem[in_fire ? h[BW-1:0] : bkt_r];
    if (clr_r) fill_mem[clr_cnt_r] <= '0;
    else if (state_r == ksbhi_pkg::S_STORE) fill_mem[bkt_r] <= n_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ksbhi_pkg::S_IDLE;
      kw_r <= 3'd1; sh_r <= '0;
      clr_r <= 1'b1; clr_cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == ksbhi_pkg::REG_KEY_WORDS) kw_r <= cfg_data[2:0];
        else if (cfg_index == ksbhi_pkg::REG_TAIL_SHIFT) sh_r <= cfg_data[5:0];
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == BW'(BUCKET_COUNT - 1)) clr_r <= 1'b0;
      end
      if (out_fire) ov_r <= 1'b0;
      if (state_r == ksbhi_pkg::S_DONE) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= key_in; pos_r <= in_ch.data.position;
      op_r <= in_ch.data.operation; bkt_r <= h[BW-1:0];
    end
    case (state_r)
      ksbhi_pkg::S_FILL: begin
        n_r <= (fill_q > NW'(BUCKET_DEPTH)) ? NW'(BUCKET_DEPTH) : fill_q;
        probe_r <= '0; phase_r <= 2'd0; lo_r <= '0; hi_r <= fill_q - 1'b1;
        slot_r <= '0;
        if (op_r == ksbhi_pkg::OP_INSERT && fill_q >= NW'(BUCKET_DEPTH))
          status_r <= ksbhi_pkg::ST_FULL;
        else if (fill_q == '0)
          status_r <= (op_r == ksbhi_pkg::OP_INSERT) ? ksbhi_pkg::ST_INSERTED
                                                     : ksbhi_pkg::ST_MISSING;
      end
      ksbhi_pkg::S_SCAN_CMP: begin
        probe_r <= probe_n; lo_r <= lo_n; hi_r <= hi_n; phase_r <= phase_n;
      end
      ksbhi_pkg::S_SHIFT_WR: idx_r <= idx_r - 1'b1;
      default: ;
    endcase
    if (state_r == ksbhi_pkg::S_SCAN_CMP && done_s) begin
      slot_r <= res_s; idx_r <= n_r;
      if (op_r == ksbhi_pkg::OP_INSERT) status_r <= ksbhi_pkg::ST_INSERTED;
      else status_r <= hit_s ? ksbhi_pkg::ST_FOUND : ksbhi_pkg::ST_MISSING;
    end
    if (state_r == ksbhi_pkg::S_DONE) begin
      ow_r.status <= status_r;
      ow_r.found_position <= (status_r == ksbhi_pkg::ST_FOUND) ? prd : '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ksbhi_checker.sv =====
`default_nettype none
`include "kmer_sorted_bucket_hash_index_assert.svh"
module ksbhi_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_status,
  input wire logic [63:0] out_pos
);
  `KSB_ASSERT_IMPL(a_no_accept_while_full, clk, rst_n, out_valid, !in_ready)
  `KSB_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
  `KSB_ASSERT_IMPL(a_zero_pos, clk, rst_n, out_valid && out_status != ksbhi_pkg::ST_FOUND, out_pos == 64'd0)
  `KSB_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind kmer_sorted_bucket_hash_index ksbhi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status), .out_pos(out_ch.data.found_position));
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
  localparam int LinearLimit = ksbhi_pkg::LinearLimitDef;
  localparam int Depth = ksbhi_pkg::BucketDepthDef;
  localparam int Buckets = ksbhi_pkg::BucketCountDef;
  localparam int DrainCycles = 60;
  localparam int CycleLimit = 1000000;

  typedef logic [3:0][ksbhi_pkg::WordW-1:0] key_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ksbhi_pkg::CfgIdxW-1:0] cfg_index;
  logic [ksbhi_pkg::CfgDataW-1:0] cfg_data;

  ksbhi_in_if in_ch ();
  ksbhi_out_if out_ch ();

  kmer_sorted_bucket_hash_index u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  key_t key_mem [Buckets][Depth];
  logic [ksbhi_pkg::WordW-1:0] pos_mem [Buckets][Depth];
  int bucket_fill [Buckets];
  logic [2:0] key_words_reg;
  logic [5:0] tail_shift_reg;

  ksbhi_pkg::out_word_t pending_responses[$];
  int mismatch_count;
  int fault_count;
  int cycle_count;
  int out_hold_cycles;
  bit no_idle;

  key_t key_pool[$];
  int hot_buckets[12];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int active_words();
    if (key_words_reg < 1) return 1;
    if (key_words_reg > ksbhi_pkg::MaxKeyWordsDef) return ksbhi_pkg::MaxKeyWordsDef;
    return key_words_reg;
  endfunction

  function automatic int key_order(key_t a, key_t b, int kw);
    for (int i = 0; i < kw; i++) begin
      if (a[i] < b[i]) return -1;
      if (a[i] > b[i]) return 1;
    end
    return 0;
  endfunction

  function automatic int insert_slot(int b, int n, key_t k, int kw);
    int s;
    int e;
    int m;
    int c;
    if (n == 0) return 0;
    if (key_order(k, key_mem[b][0], kw) <= 0) return 0;
    if (key_order(key_mem[b][n-1], k, kw) <= 0) return n;
    if (n < LinearLimit) begin
      for (int i = 1; i < n; i++)
        if (key_order(k, key_mem[b][i], kw) <= 0) return i;
      return n;
    end
    s = 0;
    e = n - 1;
    while (e - s > 1) begin
      m = (s + e) / 2;
      c = key_order(k, key_mem[b][m], kw);
      if (c < 0) e = m;
      else if (c > 0) s = m;
      else return m;
    end
    return e;
  endfunction

  function automatic int find_slot(int b, int n, key_t k, int kw);
    int s;
    int e;
    int m;
    int c;
    if (n < LinearLimit) begin
      for (int i = 0; i < n; i++)
        if (key_order(key_mem[b][i], k, kw) == 0) return i;
      return -1;
    end
    if (key_order(key_mem[b][0], k, kw) == 0) return 0;
    if (key_order(key_mem[b][n-1], k, kw) == 0) return n - 1;
    s = 0;
    e = n - 1;
    while (e - s > 1) begin
      m = (s + e) / 2;
      c = key_order(key_mem[b][m], k, kw);
      if (c == 0) return m;
      if (c > 0) e = m;
      else s = m;
    end
    return -1;
  endfunction

  function automatic ksbhi_pkg::out_word_t index_response(ksbhi_pkg::in_word_t w);
    ksbhi_pkg::out_word_t r;
    key_t k;
    logic [ksbhi_pkg::WordW-1:0] h;
    int kw;
    int b;
    int n;
    int slot;
    kw = active_words();
    k = {w.key_word3, w.key_word2, w.key_word1, w.key_word0};
    for (int i = 0; i < 4; i++)
      if (i >= kw) k[i] = '0;
    if (kw > 1 && tail_shift_reg != 0) h = (k[kw-2] << tail_shift_reg) | k[kw-1];
    else h = k[kw-1];
    b = h % Buckets;
    n = bucket_fill[b];
    r.found_position = '0;
    if (w.operation == ksbhi_pkg::OP_INSERT) begin
      if (n >= Depth) begin
        r.status = ksbhi_pkg::ST_FULL;
      end else begin
        slot = insert_slot(b, n, k, kw);
        for (int i = n; i > slot; i--) begin
          key_mem[b][i] = key_mem[b][i-1];
          pos_mem[b][i] = pos_mem[b][i-1];
        end
        key_mem[b][slot] = k;
        pos_mem[b][slot] = w.position;
        bucket_fill[b] = n + 1;
        r.status = ksbhi_pkg::ST_INSERTED;
      end
    end else begin
      slot = find_slot(b, n, k, kw);
      if (slot >= 0) begin
        r.found_position = pos_mem[b][slot];
        r.status = ksbhi_pkg::ST_FOUND;
      end else begin
        r.status = ksbhi_pkg::ST_MISSING;
      end
    end
    return r;
  endfunction

  function automatic logic [ksbhi_pkg::WordW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(logic op, key_t k, logic [ksbhi_pkg::WordW-1:0] pos);
    ksbhi_pkg::in_word_t w;
    int gap;
    w.operation = op;
    w.key_word0 = k[0];
    w.key_word1 = k[1];
    w.key_word2 = k[2];
    w.key_word3 = k[3];
    w.position = pos;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    pending_responses.push_back(index_response(w));
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    stop_sending();
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [ksbhi_pkg::CfgIdxW-1:0] idx,
                           logic [ksbhi_pkg::CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == ksbhi_pkg::REG_KEY_WORDS) key_words_reg = value[2:0];
    else tail_shift_reg = value;
  endtask

  function automatic key_t bucket_key(int b);
    key_t k;
    int kw;
    kw = active_words();
    for (int i = 0; i < 4; i++) k[i] = rand64();
    if ($urandom_range(0, 1) == 1)
      for (int i = 0; i < 4; i++) k[i][15:0] = '0;
    if (kw > 1 && tail_shift_reg != 0) k[kw-2] = '0;
    k[kw-1][9:0] = b[9:0];
    return k;
  endfunction

  initial begin
    int c;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      c = $urandom_range(0, 6);
      if (out_ch.valid && out_ch.ready) c = no_idle ? 0 : c;
      else c = -1;
      if (out_hold_cycles > 0) begin
        out_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (c > 0) begin
        out_ch.ready <= 1'b0;
        repeat (c) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ksbhi_pkg::out_word_t exp_word;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_responses.size() == 0) begin
        fault_count++;
        if (mismatch_count < 10)
          $display("Unexpected word: position %h status %0d",
                   out_ch.data.found_position, out_ch.data.status);
        mismatch_count++;
      end else begin
        exp_word = pending_responses.pop_front();
        if (out_ch.data.found_position !== exp_word.found_position) begin
          fault_count++;
          if (mismatch_count < 10)
            $display("Position mismatch: expected %h actual %h",
                     exp_word.found_position, out_ch.data.found_position);
          mismatch_count++;
        end
        if (out_ch.data.status !== exp_word.status) begin
          fault_count++;
          if (mismatch_count < 10)
            $display("Status mismatch: expected %0d actual %0d",
                     exp_word.status, out_ch.data.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    key_t k;
    key_t filled[$];
    k = '0;
    send_word(ksbhi_pkg::OP_LOOKUP, k, rand64());
    send_word(ksbhi_pkg::OP_INSERT, k, '0);
    send_word(ksbhi_pkg::OP_LOOKUP, k, rand64());
    k = '1;
    send_word(ksbhi_pkg::OP_INSERT, k, '1);
    send_word(ksbhi_pkg::OP_LOOKUP, k, '0);
    send_word(ksbhi_pkg::OP_INSERT, k, 64'h1234);
    send_word(ksbhi_pkg::OP_LOOKUP, k, '0);
    for (int i = 0; i < Depth; i++) begin
      k = bucket_key(5);
      filled.push_back(k);
      send_word(ksbhi_pkg::OP_INSERT, k, rand64());
    end
    send_word(ksbhi_pkg::OP_INSERT, bucket_key(5), rand64());
    send_word(ksbhi_pkg::OP_LOOKUP, filled[3], '0);
    send_word(ksbhi_pkg::OP_LOOKUP, filled[Depth-1], '0);
    send_word(ksbhi_pkg::OP_LOOKUP, bucket_key(5), '0);
    wait_idle();
  endtask

  task automatic run_mix(int count);
    key_t k;
    logic [ksbhi_pkg::WordW-1:0] pos;
    key_pool.delete();
    foreach (hot_buckets[i]) hot_buckets[i] = $urandom_range(0, Buckets - 1);
    for (int n = 0; n < count; n++) begin
      pos = ($urandom_range(0, 15) == 0) ? '0 : rand64();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 4; i++) k[i] = rand64();
      end else if (key_pool.size() > 0 && $urandom_range(0, 9) < 4) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        k = bucket_key(hot_buckets[$urandom_range(0, 11)]);
        key_pool.push_back(k);
      end
      send_word($urandom_range(0, 9) < 4 ? ksbhi_pkg::OP_LOOKUP : ksbhi_pkg::OP_INSERT,
                k, pos);
    end
    wait_idle();
  endtask

  task automatic test_key_layouts();
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd2);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'd0);
    run_mix(200);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'd1);
    run_mix(200);
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd4);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'd63);
    run_mix(200);
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd3);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'($urandom_range(2, 62)));
    run_mix(200);
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd0);
    run_mix(200);
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd7);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'd10);
    run_mix(200);
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd1);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'd0);
    run_mix(200);
  endtask

  task automatic test_back_pressure();
    out_hold_cycles = 400;
    run_mix(40);
    write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'd4);
    write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'd5);
    out_hold_cycles = 300;
    run_mix(40);
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    run_mix(150);
    no_idle = 1'b0;
  endtask

  task automatic test_random_run();
    for (int p = 0; p < 3; p++) begin
      write_reg(ksbhi_pkg::REG_KEY_WORDS, 6'($urandom_range(0, 7)));
      write_reg(ksbhi_pkg::REG_TAIL_SHIFT, 6'($urandom_range(0, 63)));
      run_mix(100);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    mismatch_count = 0;
    fault_count = 0;
    out_hold_cycles = 0;
    no_idle = 1'b0;
    key_words_reg = 3'd1;
    tail_shift_reg = 6'd0;
    foreach (bucket_fill[i]) bucket_fill[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_key_layouts();
    test_back_pressure();
    test_full_rate();
    test_random_run();
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/ksbhi_pkg.sv
rtl/ksbhi_if.sv
rtl/ksbhi_store.sv
rtl/kmer_sorted_bucket_hash_index.sv
rtl/ksbhi_checker.sv
tb/sv/tb.sv
